### hdl/assert_macros.svh
// Assertion helpers for the RTL file that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clk edge, masked while rst_n is low.
`define DBD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every rising clk edge, reset included.
`define DBD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/dbd_pkg.sv
`default_nettype none

package dbd_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 22;
    localparam int ORD_W   = 23;   // per-date ordinal, up to ~6.0M days
    localparam int DBM_W   = 9;    // days before month, up to 334
    localparam int MD_W    = 10;   // month offset + day + leap day
    localparam int QUO_W   = 8;    // year / 100, up to 163

    // x / 25 for x < 4096 as (x * 5243) >> 17
    localparam logic [12:0] DIV25_MUL   = 13'd5243;
    localparam int          DIV25_SHIFT = 17;
    localparam int          PROD_W      = 25;

    localparam logic [MONTH_W-1:0] MONTH_MARCH = 4'd3;

    typedef logic [YEAR_W-1:0]  year_t;
    typedef logic [MONTH_W-1:0] month_t;
    typedef logic [DAY_W-1:0]   day_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [ORD_W-1:0]   ord_t;
    typedef logic [PROD_W-1:0]  prod_t;

    localparam count_t COUNT_MAX = '1;

    // Stage load enables from the pipeline control.
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
        logic en4;
    } pipe_ctrl_t;

    // Days before the first of the month in a common year.
    // Month 0 counts as January, 13..15 as December.
    function automatic logic [DBM_W-1:0] days_before_month(input month_t m);
        logic [DBM_W-1:0] r;
        case (m) inside
            4'd0, 4'd1: r = 9'd0;
            4'd2:       r = 9'd31;
            4'd3:       r = 9'd59;
            4'd4:       r = 9'd90;
            4'd5:       r = 9'd120;
            4'd6:       r = 9'd151;
            4'd7:       r = 9'd181;
            4'd8:       r = 9'd212;
            4'd9:       r = 9'd243;
            4'd10:      r = 9'd273;
            4'd11:      r = 9'd304;
            [4'd12:4'd15]: r = 9'd334;
            default:    r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/dbd_in_if.sv
`default_nettype none

interface dbd_in_if;
    import dbd_pkg::*;

    logic   valid;
    logic   ready;
    year_t  first_year;
    month_t first_month;
    day_t   first_day;
    year_t  second_year;
    month_t second_month;
    day_t   second_day;

    modport source (
        output valid, first_year, first_month, first_day,
               second_year, second_month, second_day,
        input  ready
    );

    modport sink (
        input  valid, first_year, first_month, first_day,
               second_year, second_month, second_day,
        output ready
    );
endinterface

`default_nettype wire

### hdl/dbd_out_if.sv
`default_nettype none

interface dbd_out_if;
    import dbd_pkg::*;

    logic   valid;
    logic   ready;
    count_t day_count;
    logic   order_error;

    modport source (
        output valid, day_count, order_error,
        input  ready
    );

    modport sink (
        input  valid, day_count, order_error,
        output ready
    );
endinterface

`default_nettype wire

### hdl/dbd_ctrl.sv
`default_nettype none

// Valid bits of the four stages and the backward ready chain.
module dbd_ctrl
    import dbd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    output pipe_ctrl_t      pipe
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic can1, can2, can3, can4;

    // a stage can load when it is empty or its content moves on
    assign can4 = !v4_reg || out_ready;
    assign can3 = !v3_reg || can4;
    assign can2 = !v2_reg || can3;
    assign can1 = !v1_reg || can2;

    assign pipe.en1 = can1 && in_valid;
    assign pipe.en2 = can2 && v1_reg;
    assign pipe.en3 = can3 && v2_reg;
    assign pipe.en4 = can4 && v3_reg;

    assign in_ready  = can1;
    assign out_valid = v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (can1)
            begin
                v1_reg <= in_valid;
            end
            if (can2)
            begin
                v2_reg <= v1_reg;
            end
            if (can3)
            begin
                v3_reg <= v2_reg;
            end
            if (can4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/dbd_ordinal.sv
`default_nettype none

// Day ordinal of one date over three stages:
//   1: quotient multiplies, month table
//   2: whole-year days, leap test
//   3: final sum
// Result is days(year) + month offset + leap day + day (one above the
// zero-based ordinal, which keeps day 0 of year 0 at zero).
module dbd_ordinal
    import dbd_pkg::*;
(
    input  wire logic       clk,
    input  wire pipe_ctrl_t pipe,
    input  wire year_t      year,
    input  wire month_t     month,
    input  wire day_t       day,
    output ord_t            ord
);

    // stage 1
    year_t              y1_reg;
    logic [DBM_W-1:0]   dbm1_reg;
    logic               late1_reg;
    day_t               d1_reg;
    prod_t              nprod1_reg;
    prod_t              yprod1_reg;
    // stage 2
    ord_t               base2_reg;
    logic [MD_W-1:0]    md2_reg;
    // stage 3
    ord_t               ord3_reg;

    year_t              year_m1;
    year_t              year_m1_s1;
    logic [11:0]        nq4_in;
    logic [11:0]        nq4;
    logic [11:0]        yq4;
    logic [QUO_W-1:0]   p;
    logic [QUO_W-1:0]   qy;
    ord_t               y365;
    ord_t               base_next;
    logic               div4;
    logic               cent;
    logic               leap;
    logic [MD_W-1:0]    md_next;

    assign year_m1 = year - year_t'(1);
    assign nq4_in  = year_m1[YEAR_W-1:2];

    always_ff @(posedge clk)
    begin
        if (pipe.en1)
        begin
            y1_reg     <= year;
            dbm1_reg   <= days_before_month(month);
            late1_reg  <= (month >= MONTH_MARCH);
            d1_reg     <= day;
            nprod1_reg <= prod_t'(nq4_in) * prod_t'(DIV25_MUL);
            yprod1_reg <= prod_t'(year[YEAR_W-1:2]) * prod_t'(DIV25_MUL);
        end
    end

    // (y-1)/100 = ((y-1)>>2)/25; /400 and /3200 follow by shifting that
    assign year_m1_s1 = y1_reg - year_t'(1);
    assign nq4  = year_m1_s1[YEAR_W-1:2];
    assign yq4  = y1_reg[YEAR_W-1:2];
    assign p    = nprod1_reg[PROD_W-1:DIV25_SHIFT];
    assign qy   = yprod1_reg[PROD_W-1:DIV25_SHIFT];
    assign y365 = ord_t'(y1_reg) * ord_t'(365);

    always_comb
    begin
        if (y1_reg == '0)
        begin
            base_next = '0;
        end
        else
        begin
            base_next = y365 + ord_t'(nq4) - ord_t'(p)
                      + ord_t'(p[QUO_W-1:2]) - ord_t'(p[QUO_W-1:5]);
        end
    end

    // y%100 == 0 when y%4 == 0 and y/4 is a multiple of 25; then
    // y%400 and y%3200 reduce to the low bits of y/100
    assign div4 = (y1_reg[1:0] == 2'd0);
    assign cent = div4 && ({1'b0, yq4} == (13'(qy) * 13'd25));
    assign leap = div4 && (!cent || ((qy[1:0] == 2'd0) && (qy[4:0] != 5'd0)));

    assign md_next = MD_W'(dbm1_reg) + MD_W'(d1_reg) + MD_W'(leap && late1_reg);

    always_ff @(posedge clk)
    begin
        if (pipe.en2)
        begin
            base2_reg <= base_next;
            md2_reg   <= md_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe.en3)
        begin
            ord3_reg <= base2_reg + ord_t'(md2_reg);
        end
    end

    assign ord = ord3_reg;

endmodule

`default_nettype wire

### hdl/days_between_dates_unit.sv
`default_nettype none
`include "assert_macros.svh"

// Day count between two calendar dates. Each item on the dates channel
// carries a first and a second date (year, month, day); each result on
// the result channel carries the number of days from the first date to
// the second. Leap years follow the rule "divisible by 4 and not by 100,
// or by 400 and not by 3200". Days and months are not checked: month 0
// counts as January, months 13 to 15 as December, and an out-of-range day
// simply shifts the date by that many days. When the first date lies
// after the second, order_error is set and day_count is zero; a count
// above the 22-bit range saturates to all ones. The block is a four-stage
// pipeline with no state between items: a new item can be taken every
// cycle unless a stall on the result side has filled every stage. Stage 1
// runs the two divide-by-25 reciprocal multiplies per date that give the
// century counts, stage 2 builds the whole-year day count and the leap
// test, stage 3 sums each date's ordinal, stage 4 subtracts, checks order
// and saturates. A stall on the result side holds stage 4 and each full
// stage directly behind it; the other stages keep moving and filling.
// Reset clears only the valid bits; no memory needs clearing.
module days_between_dates_unit
    import dbd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    dbd_in_if.sink      dates,
    dbd_out_if.source   result
);

    pipe_ctrl_t pipe;
    ord_t       ord_first;
    ord_t       ord_second;

    // output stage
    count_t     count4_reg;
    logic       err4_reg;

    ord_t       diff;
    logic       err_next;
    count_t     count_next;

    dbd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dates.valid),
        .in_ready  (dates.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .pipe      (pipe)
    );

    dbd_ordinal u_first (
        .clk   (clk),
        .pipe  (pipe),
        .year  (dates.first_year),
        .month (dates.first_month),
        .day   (dates.first_day),
        .ord   (ord_first)
    );

    dbd_ordinal u_second (
        .clk   (clk),
        .pipe  (pipe),
        .year  (dates.second_year),
        .month (dates.second_month),
        .day   (dates.second_day),
        .ord   (ord_second)
    );

    // Both ordinals carry the same +1 offset, so it cancels here.
    assign diff     = ord_second - ord_first;
    assign err_next = (ord_first > ord_second);

    always_comb
    begin
        if (err_next)
        begin
            count_next = '0;
        end
        else if (diff[ORD_W-1])
        begin
            count_next = COUNT_MAX;     // beyond 22 bits
        end
        else
        begin
            count_next = diff[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe.en4)
        begin
            count4_reg <= count_next;
            err4_reg   <= err_next;
        end
    end

    assign result.day_count   = count4_reg;
    assign result.order_error = err4_reg;

    // An order error always comes with a zero count.
    `DBD_ASSERT(a_err_zero, result.valid && result.order_error |-> result.day_count == '0, "order error with nonzero count")

    // Input back-pressure only arises from a full pipe behind a stalled result.
    `DBD_ASSERT(a_ready_chain, !dates.ready |-> result.valid && !result.ready, "input stalled without output stall")

    // No result is offered once reset has been applied.
    `DBD_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !result.valid, "result valid during reset")

endmodule

`default_nettype wire

### dv/days_between_dates_checker.sv
`timescale 1ns / 100ps

module days_between_dates_checker
    import dbd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    dbd_in_if         dates,
    dbd_out_if        result,
    output int        fail_count,
    output int        pending,
    output int        spans_checked,
    output int        order_errors,
    output int        saturations
);

    typedef struct packed {
        count_t day_count;
        logic   order_error;
    } span_t;

    // days before the first of each month, common year
    localparam int unsigned MONTH_START [12] = '{
        0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
    };

    span_t span_q [$];
    int    n_fail    = 0;
    int    n_checked = 0;
    int    n_order   = 0;
    int    n_sat     = 0;

    function automatic bit is_leap(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || ((y % 400 == 0) && (y % 3200 != 0));
    endfunction

    // Days up to and including the given date; day 0 lands one below day 1.
    function automatic int unsigned day_serial(input year_t y, input month_t m, input day_t d);
        int unsigned yy;
        int unsigned n;
        int unsigned mm;
        int unsigned s;
        yy = y;
        s  = 0;
        if (yy != 0)
        begin
            n = yy - 1;
            s = 365 * yy + n / 4 - n / 100 + n / 400 - n / 3200;
        end
        mm = (m == 0) ? 1 : ((m > 12) ? 12 : m);
        s += MONTH_START[mm - 1];
        if (mm >= 3 && is_leap(yy))
            s += 1;
        s += d;
        return s;
    endfunction

    function automatic span_t predict_span(input year_t y1, input month_t m1, input day_t d1,
                                           input year_t y2, input month_t m2, input day_t d2);
        int unsigned sa;
        int unsigned sb;
        int unsigned diff;
        span_t       r;
        sa = day_serial(y1, m1, d1);
        sb = day_serial(y2, m2, d2);
        if (sa > sb)
        begin
            r.day_count   = '0;
            r.order_error = 1'b1;
        end
        else
        begin
            diff          = sb - sa;
            r.day_count   = (diff > COUNT_MAX) ? COUNT_MAX : count_t'(diff);
            r.order_error = 1'b0;
        end
        return r;
    endfunction

    always @(posedge clk)
    begin : monitor
        span_t want;
        if (rst_n)
        begin
            if (dates.valid && dates.ready)
                span_q.push_back(predict_span(dates.first_year, dates.first_month,
                                              dates.first_day, dates.second_year,
                                              dates.second_month, dates.second_day));
            if (result.valid && result.ready)
            begin
                if (span_q.size() == 0)
                begin
                    $display("%0t: unexpected result, day_count %0d order_error %0b",
                             $time, result.day_count, result.order_error);
                    n_fail++;
                end
                else
                begin
                    want = span_q.pop_front();
                    n_checked++;
                    if (result.day_count !== want.day_count)
                    begin
                        $display("%0t: day_count mismatch, expected %0d, actual %0d",
                                 $time, want.day_count, result.day_count);
                        n_fail++;
                    end
                    if (result.order_error !== want.order_error)
                    begin
                        $display("%0t: order_error mismatch, expected %0b, actual %0b",
                                 $time, want.order_error, result.order_error);
                        n_fail++;
                    end
                    if (want.order_error)
                        n_order++;
                    else if (want.day_count == COUNT_MAX)
                        n_sat++;
                end
            end
        end
        fail_count    <= n_fail;
        pending       <= span_q.size();
        spans_checked <= n_checked;
        order_errors  <= n_order;
        saturations   <= n_sat;
    end

endmodule

### dv/days_between_dates_unit_tb.sv
`timescale 1ns / 100ps

module days_between_dates_unit_tb;
    import dbd_pkg::*;

    localparam int RANDOM_ITEMS = 850;
    localparam int IDLE_PCT     = 13;     // idle / stall chance per cycle, percent
    localparam int STALL_LIMIT  = 5000;   // cycles with no item moved on either side
    localparam int DRAIN_CYCLES = 8;      // four-stage pipe plus margin

    typedef struct packed {
        year_t  y;
        month_t m;
        day_t   d;
    } date_t;

    logic clk;
    logic rst_n;
    logic steady;       // when high, neither side idles
    int   items_sent;
    int   idle_cycles;
    int   fail_count;
    int   pending;
    int   spans_checked;
    int   order_errors;
    int   saturations;

    dbd_in_if  dates ();
    dbd_out_if result ();

    days_between_dates_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .dates  (dates),
        .result (result)
    );

    // Scoreboard sits beside the DUT and only watches the two channels.
    days_between_dates_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .dates         (dates),
        .result        (result),
        .fail_count    (fail_count),
        .pending       (pending),
        .spans_checked (spans_checked),
        .order_errors  (order_errors),
        .saturations   (saturations)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Result side: random backpressure, none while steady is set.
    always @(posedge clk)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else
            result.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog: a hung handshake on either channel ends the run.
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((dates.valid && dates.ready) || (result.valid && result.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic date_t mk(input int y, input int m, input int d);
        date_t r;
        r.y = year_t'(y);
        r.m = month_t'(m);
        r.d = day_t'(d);
        return r;
    endfunction

    // Date inside the given year range, month 1 to 12 and day 1 to 31.
    function automatic date_t rand_date(input int lo, input int hi);
        return mk($urandom_range(hi, lo), $urandom_range(12, 1), $urandom_range(31, 1));
    endfunction

    // Presents one date pair and holds it until accepted. Valid stays high
    // across back-to-back items; an idle cycle drops it for one edge.
    task automatic send_span(input date_t a, input date_t b);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            dates.valid <= 1'b0;
            @(posedge clk);
        end
        dates.valid        <= 1'b1;
        dates.first_year   <= a.y;
        dates.first_month  <= a.m;
        dates.first_day    <= a.d;
        dates.second_year  <= b.y;
        dates.second_month <= b.m;
        dates.second_day   <= b.d;
        @(posedge clk);
        while (!dates.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Holds the sender off until every predicted result has come back.
    // The extra edge lets the checker count the item taken at this edge.
    task automatic wait_drained;
        dates.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        date_t a;
        date_t b;
        date_t t;
        int    kind;
        int    y;

        rst_n              = 1'b0;
        steady             = 1'b0;
        items_sent         = 0;
        dates.valid        = 1'b0;
        dates.first_year   = '0;
        dates.first_month  = '0;
        dates.first_day    = '0;
        dates.second_year  = '0;
        dates.second_month = '0;
        dates.second_day   = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed edge cases ----
        send_span(mk(2000, 1, 1), mk(2000, 1, 1));            // same date
        send_span(mk(1, 1, 1), mk(9999, 12, 31));             // full legal span
        send_span(mk(0, 0, 0), mk(16383, 15, 31));            // all-zero vs all-ones, saturates
        send_span(mk(16383, 15, 31), mk(0, 0, 0));            // same, reversed
        send_span(mk(2024, 3, 1), mk(2024, 2, 29));           // reversed by a day
        send_span(mk(2023, 1, 2), mk(2023, 1, 1));            // reversed by a day, common year
        send_span(mk(2024, 2, 28), mk(2024, 3, 1));           // plain leap year
        send_span(mk(1900, 2, 28), mk(1900, 3, 1));           // century, not leap
        send_span(mk(2000, 2, 28), mk(2000, 3, 1));           // 400 rule, leap
        send_span(mk(3200, 2, 28), mk(3200, 3, 1));           // 3200 rule, not leap
        send_span(mk(6400, 2, 28), mk(9600, 3, 1));
        send_span(mk(2023, 5, 0), mk(2023, 5, 1));            // day zero
        send_span(mk(0, 0, 0), mk(0, 1, 0));                  // year zero, month zero, day zero
        send_span(mk(0, 1, 1), mk(1, 1, 1));                  // year zero is a common year
        send_span(mk(2023, 0, 5), mk(2023, 1, 5));            // month zero acts as January
        send_span(mk(2024, 13, 1), mk(2024, 12, 1));          // months past 12 act as December
        send_span(mk(2024, 14, 9), mk(2024, 15, 9));
        send_span(mk(2023, 2, 31), mk(2023, 3, 3));           // day past month end
        send_span(mk(2023, 1, 32 - 1), mk(2023, 2, 0));       // Jan 31 vs Feb 0, equal
        send_span(mk(12000, 1, 1), mk(13000, 1, 1));          // beyond 9999, no saturation
        send_span(mk(14'h2AAA, 4'h5, 5'h0A), mk(14'h1555, 4'hA, 5'h15));
        send_span(mk(14'h1555, 4'hA, 5'h15), mk(14'h2AAA, 4'h5, 5'h0A));
        wait_drained();

        // ---- random phase ----
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if ((i == 300) != (steady == 1'b1) && (i == 300 || i == 450))
                steady <= (i == 300);
            if (i == 500)
                wait_drained();
            kind = $urandom_range(99);
            if (kind < 45)
            begin
                // arbitrary dates in years 1 to 9999, put in order
                a = rand_date(1, 9999);
                b = rand_date(1, 9999);
                if (a > b)
                begin
                    t = a;
                    a = b;
                    b = t;
                end
            end
            else if (kind < 60)
            begin
                // short spans within a year or across one boundary
                a   = rand_date(1, 9998);
                b   = rand_date(1, 1);
                b.y = a.y + year_t'($urandom_range(1, 0));
                if (a > b)
                begin
                    t = a;
                    a = b;
                    b = t;
                end
            end
            else if (kind < 72)
            begin
                // around February of century, 400 and 3200 years
                if ($urandom_range(3) == 0)
                    y = $urandom_range(5, 1) * 3200;
                else
                    y = $urandom_range(99, 1) * 100;
                y = y + $urandom_range(2) - 1;
                a = mk(y, 2, $urandom_range(29, 27));
                b = mk(y + $urandom_range(1, 0), $urandom_range(3, 2), $urandom_range(2, 1));
            end
            else if (kind < 85)
            begin
                // dates in years 1 to 9999 handed over in the wrong order
                a = rand_date(1, 9999);
                b = rand_date(1, 9999);
                if (a < b)
                begin
                    t = a;
                    a = b;
                    b = t;
                end
            end
            else
            begin
                // full-width noise on every field
                a = date_t'($urandom);
                b = date_t'($urandom);
            end
            send_span(a, b);
        end

        // ---- drain and verdict ----
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d date pairs, checked %0d results: %0d out of order, %0d saturated.",
                 items_sent, spans_checked, order_errors, saturations);
        $display("Edge dates, leap-rule boundaries, reversed pairs and noise, "
                 , "with random idling and backpressure.");
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### days_between_dates_unit.f
+incdir+hdl
hdl/dbd_pkg.sv
hdl/dbd_in_if.sv
hdl/dbd_out_if.sv
hdl/dbd_ctrl.sv
hdl/dbd_ordinal.sv
hdl/days_between_dates_unit.sv
dv/days_between_dates_checker.sv
dv/days_between_dates_unit_tb.sv
